FILE: src/multichannel_median3_filter_defines.svh
// Assertion macros used by the checker file of the median filter.
// Both macros sample on the rising edge of clk and are idle while arst_n is low.
`ifndef MULTICHANNEL_MEDIAN3_FILTER_DEFINES_SVH
`define MULTICHANNEL_MEDIAN3_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCM3_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("median filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCM3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("median filter check failed");

`endif

FILE: src/mcm3_pkg.sv
package mcm3_pkg;

	localparam int CHANNELS = 8;
	localparam int CHAN_W   = 3;
	localparam int RAW_W    = 12;
	localparam int SAMPLE_W = RAW_W + 1;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [RAW_W-1:0] OFFSET_RST = RAW_W'(12'h800);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Per-channel record held in the state memory.
	typedef struct packed {
		sample_t h0;    // newest sample
		sample_t h1;    // sample before that
		sample_t last;  // previous filtered value
	} chan_state_t;

	localparam int STATE_W = $bits(chan_state_t);

	typedef struct packed {
		chan_state_t nxt;
		logic        changed;
	} upd_res_t;

endpackage

FILE: src/mcm3_ram.sv
module mcm3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/mcm3_update.sv
module mcm3_update (
	input  mcm3_pkg::sample_t     sample,
	input  mcm3_pkg::chan_state_t cur,
	output mcm3_pkg::upd_res_t    res
);
	import mcm3_pkg::*;

	sample_t lo_ab;
	sample_t hi_ab;
	sample_t lo_hc;
	sample_t med;

	// Median of the new sample and the two stored ones:
	// max(min(a, b), min(max(a, b), c)).
	always_comb begin
		lo_ab = (sample < cur.h0) ? sample : cur.h0;
		hi_ab = (sample > cur.h0) ? sample : cur.h0;
		lo_hc = (hi_ab < cur.h1) ? hi_ab : cur.h1;
		med   = (lo_ab > lo_hc) ? lo_ab : lo_hc;

		res.nxt.h0   = sample;
		res.nxt.h1   = cur.h0;
		res.nxt.last = med;
		res.changed  = (med != cur.last);
	end

endmodule

FILE: src/multichannel_median3_filter.sv
// Channel   | Direction | Handshake          | Payload
// input     | in        | in_valid/in_stall  | channel, raw_sample
// output    | out       | out_valid/out_stall| channel_out, filtered_value, changed
// config    | in        | cfg_wr_en          | cfg_wr_data (offset)
//
// Unless stalled, one item per cycle is taken; it passes stage 1 and the output register.
// The per-channel state lives in a RAM with a registered read; a register holding
// the last write forwards it when back-to-back items hit the same channel.
// Reset clears per-channel valid bits, so no clearing pass is needed.
// A stall on a waiting result holds the pipeline and, while stage 1 holds an item,
// raises in_stall in the same cycle.
module multichannel_median3_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mcm3_pkg::RAW_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mcm3_pkg::CHAN_W-1:0]  channel,
	input  logic [mcm3_pkg::RAW_W-1:0]   raw_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mcm3_pkg::CHAN_W-1:0]  channel_out,
	output mcm3_pkg::sample_t            filtered_value,
	output logic                         changed
);
	import mcm3_pkg::*;

	logic [RAW_W-1:0]    offset_q;

	logic                valid_s1;
	logic                in_range_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [CH_AW-1:0]    addr_s1;
	sample_t             sample_s1;

	logic [CHANNELS-1:0] entry_valid_q;
	logic                wr_en_q;
	logic [CH_AW-1:0]    wr_addr_q;
	chan_state_t         wr_data_q;

	logic                out_valid_q;
	logic [CHAN_W-1:0]   chan_out_q;
	sample_t             filt_q;
	logic                changed_q;

	logic                in_accept;
	logic                advance;
	logic                mem_we;
	logic [CH_AW-1:0]    rd_addr;
	logic [STATE_W-1:0]  rd_data;
	chan_state_t         cur_state;
	upd_res_t            upd;
	sample_t             sample_in;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign rd_addr   = CH_AW'(channel);
	assign sample_in = sample_t'({1'b0, offset_q}) - sample_t'({1'b0, raw_sample});
	assign mem_we    = valid_s1 && advance && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RST;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	mcm3_ram #(
		.WIDTH(STATE_W),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(addr_s1),
		.wdata(upd.nxt),
		.re   (in_accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			chan_s1     <= channel;
			addr_s1     <= rd_addr;
			in_range_s1 <= (32'(channel) < CHANNELS);
			sample_s1   <= sample_in;
		end
	end

	// The RAM read issued with an item misses the write made on the same edge,
	// so the last write is kept and used when the channel matches.
	always_comb begin
		if (wr_en_q && (wr_addr_q == addr_s1)) begin
			cur_state = wr_data_q;
		end else if (in_range_s1 && entry_valid_q[addr_s1]) begin
			cur_state = chan_state_t'(rd_data);
		end else begin
			cur_state = '0;
		end
	end

	mcm3_update u_update (
		.sample(sample_s1),
		.cur   (cur_state),
		.res   (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			wr_en_q       <= 1'b0;
		end else if (mem_we) begin
			entry_valid_q[addr_s1] <= 1'b1;
			wr_en_q                <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= upd.nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			chan_out_q <= chan_s1;
			filt_q     <= in_range_s1 ? upd.nxt.last : '0;
			changed_q  <= in_range_s1 && upd.changed;
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_out    = chan_out_q;
	assign filtered_value = filt_q;
	assign changed        = changed_q;

endmodule

FILE: src/mcm3_checker.sv
`include "multichannel_median3_filter_defines.svh"

module mcm3_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [mcm3_pkg::CHAN_W-1:0]  channel_out,
	input mcm3_pkg::sample_t            filtered_value,
	input logic                         changed
);
	import mcm3_pkg::*;

	// The input only backs up when a result is waiting and is itself held.
	`MCM3_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// A median of 13-bit samples never reaches the most negative code.
	`MCM3_ASSERT_NOW(a_value_range, out_valid, filtered_value != {1'b1, {(SAMPLE_W-1){1'b0}}})

	// Items for channels the block does not keep give a zero result.
	`MCM3_ASSERT_NOW(a_unkept_chan, out_valid && (32'(channel_out) >= CHANNELS),
		(filtered_value == '0) && !changed)

	`MCM3_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(filtered_value) && $stable(channel_out) && $stable(changed))

endmodule

bind multichannel_median3_filter mcm3_checker u_mcm3_checker (.*);

FILE: tb/multichannel_median3_filter_tb.sv
module multichannel_median3_filter_tb;
	import mcm3_pkg::*;

	typedef struct {
		logic [CHAN_W-1:0] ch;
		logic [RAW_W-1:0]  raw;
	} reading_t;

	typedef struct {
		logic [CHAN_W-1:0] ch;
		sample_t           value;
		logic              changed;
	} filtered_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [RAW_W-1:0]  cfg_wr_data = OFFSET_RST;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CHAN_W-1:0] channel = '0;
	logic [RAW_W-1:0]  raw_sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CHAN_W-1:0] channel_out;
	sample_t           filtered_value;
	logic              changed;

	reading_t  pending_readings[$];
	filtered_t expected_filtered[$];

	// Predictor state: offset, three-deep history and last median per channel.
	logic [RAW_W-1:0] offset_model = OFFSET_RST;
	sample_t          hist0[CHANNELS] = '{default: '0};
	sample_t          hist1[CHANNELS] = '{default: '0};
	sample_t          hist2[CHANNELS] = '{default: '0};
	sample_t          last_med[CHANNELS] = '{default: '0};

	int gap_left = 0;
	int stall_left = 0;
	int in_burst = 0;
	int out_burst = 0;
	int mismatches = 0;

	multichannel_median3_filter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.raw_sample     (raw_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.channel_out    (channel_out),
		.filtered_value (filtered_value),
		.changed        (changed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic sample_t middle_of(sample_t a, sample_t b, sample_t c);
		if ((a >= b && a <= c) || (a <= b && a >= c))
			return a;
		if ((b >= a && b <= c) || (b <= a && b >= c))
			return b;
		return c;
	endfunction

	// Mostly a short random pause, with occasional runs of back-to-back items.
	function automatic int draw_pause(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	task automatic apply_reading(input logic [CHAN_W-1:0] ch, input logic [RAW_W-1:0] raw);
		filtered_t e;
		sample_t   s;
		sample_t   m;
		e.ch = ch;
		e.value = '0;
		e.changed = 1'b0;
		if (ch < CHANNELS) begin
			s = sample_t'(int'(offset_model) - int'(raw));
			hist2[ch] = hist1[ch];
			hist1[ch] = hist0[ch];
			hist0[ch] = s;
			m = middle_of(hist0[ch], hist1[ch], hist2[ch]);
			e.changed = (m != last_med[ch]);
			last_med[ch] = m;
			e.value = m;
		end
		expected_filtered.push_back(e);
	endtask

	task automatic queue_reading(input int ch, input int raw);
		reading_t r;
		r.ch = ch[CHAN_W-1:0];
		r.raw = raw[RAW_W-1:0];
		pending_readings.push_back(r);
	endtask

	// Random readings: channel repeats are common so that back-to-back items
	// hit the same history, and repeated raw values keep the median steady.
	task automatic queue_random(input int count);
		int ch;
		int raw;
		int prev_ch;
		int prev_raw;
		prev_ch = $urandom_range(0, 7);
		prev_raw = $urandom_range(0, 4095);
		for (int i = 0; i < count; i++) begin
			ch = ($urandom_range(0, 99) < 45) ? prev_ch : $urandom_range(0, 7);
			case ($urandom_range(0, 9))
				0: raw = 0;
				1: raw = 4095;
				2, 3: raw = prev_raw;
				4, 5: begin
					raw = int'(offset_model) + $urandom_range(0, 16) - 8;
					if (raw < 0)
						raw = 0;
					if (raw > 4095)
						raw = 4095;
				end
				default: raw = $urandom_range(0, 4095);
			endcase
			queue_reading(ch, raw);
			prev_ch = ch;
			prev_raw = raw;
		end
	endtask

	// Sampled on the falling edge so that the driver's updates have settled.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_readings.size() != 0 || in_valid || expected_filtered.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [RAW_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		offset_model = v;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_readings
		logic     holding;
		reading_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			channel <= '0;
			raw_sample <= '0;
			gap_left = 0;
		end else begin
			holding = in_valid;
			if (in_valid && !in_stall) begin
				apply_reading(channel, raw_sample);
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_readings.size() > 0) begin
					nxt = pending_readings.pop_front();
					channel <= nxt.ch;
					raw_sample <= nxt.raw;
					holding = 1'b1;
					gap_left = draw_pause(in_burst);
				end
			end
			in_valid <= holding;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		filtered_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_filtered.size() == 0) begin
					$error("unexpected result: channel_out=%0d filtered_value=%0d",
						channel_out, filtered_value);
					mismatches++;
				end else begin
					e = expected_filtered.pop_front();
					if (channel_out !== e.ch) begin
						$error("channel_out: expected %0d, got %0d", e.ch, channel_out);
						mismatches++;
					end
					if (filtered_value !== e.value) begin
						$error("filtered_value: expected %0d, got %0d", e.value,
							filtered_value);
						mismatches++;
					end
					if (changed !== e.changed) begin
						$error("changed: expected %0d, got %0d", e.changed, changed);
						mismatches++;
					end
				end
				stall_left = draw_pause(out_burst);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	initial begin : stimulus
		logic [RAW_W-1:0] offsets[8];
		offsets = '{12'h000, 12'hFFF, 12'h800, 12'h000, 12'h000, 12'h7FF, 12'h000, 12'h001};
		offsets[3] = $urandom_range(0, 4095);
		offsets[4] = $urandom_range(0, 4095);
		offsets[6] = $urandom_range(0, 4095);

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset offset: the median on channel 0 moves once two of three samples agree.
		queue_reading(0, 0);
		queue_reading(0, 0);
		queue_reading(0, 4095);
		queue_reading(0, 2048);
		queue_reading(1, 4095);
		queue_reading(2, 1);
		queue_reading(3, 2047);
		queue_reading(4, 2049);
		queue_reading(5, 12'hAAA);
		queue_reading(6, 12'h555);
		queue_reading(7, 4094);
		wait_idle();

		// Largest positive sample.
		write_offset(12'hFFF);
		repeat (3) queue_reading(3, 0);
		queue_reading(3, 4095);
		wait_idle();

		// Largest negative sample.
		write_offset(12'h000);
		repeat (3) queue_reading(5, 4095);
		queue_reading(6, 0);
		wait_idle();

		foreach (offsets[i]) begin
			write_offset(offsets[i]);
			queue_random(210);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_filtered.size() == 0)
			$display("multichannel_median3_filter_tb: PASS");
		else
			$display("multichannel_median3_filter_tb: FAIL");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("multichannel_median3_filter_tb: FAIL");
		$finish;
	end

endmodule
